>>> src/haze_removal_pixel_assert.svh
// Assertion macros shared by the haze removal RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef HAZE_REMOVAL_PIXEL_ASSERT_SVH
`define HAZE_REMOVAL_PIXEL_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define HZR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("haze_removal_pixel: implication check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define HZR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("haze_removal_pixel: next-cycle check failed");

`endif

>>> src/hzr_pkg.sv
package hzr_pkg;

    // Fraction bits of the phi gain; phi lies in [1, 2], so two integer bits.
    localparam int PHI_FRAC_BITS = 15;
    localparam int PHI_W         = PHI_FRAC_BITS + 2;
    localparam int ROM_DEPTH     = 256;
    localparam int ROM_IDX_W     = $clog2(ROM_DEPTH);

    // Channel and luminance widths.
    localparam int CHAN_W = 8;
    localparam int LUM_W  = 15;
    localparam logic [LUM_W-1:0] LUM_MAX = LUM_W'(25500);

    // Scaling datapath widths: product c*phi, then times 39, then divided
    // by 8 * 2^PHI_FRAC_BITS.
    localparam int PROD_W = CHAN_W + PHI_W;
    localparam int X_W    = PROD_W + 6;
    localparam int QUO_W  = X_W - (PHI_FRAC_BITS + 3);

    // Reciprocals for division by small constants.
    localparam logic [11:0] DIV5_RECIP   = 12'd3277;
    localparam int          DIV5_SHIFT   = 14;
    localparam logic [12:0] DIV100_RECIP = 13'd5243;
    localparam int          DIV100_SHIFT = 19;

    // Luminance weights in hundredths.
    localparam logic [6:0] LUM_WR = 7'd27;
    localparam logic [6:0] LUM_WG = 7'd67;
    localparam logic [6:0] LUM_WB = 7'd6;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HAZE_MEAN   = 1'b0,
        CFG_HAZE_SPREAD = 1'b1
    } cfg_index_t;

    typedef logic [CHAN_W-1:0] chan_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } pixel_t;

    // Payload that travels unchanged alongside the arithmetic.
    typedef struct packed {
        pixel_t orig;
        logic   hazy;
        logic   user;
        logic   last;
    } hzr_carry_t;

    typedef logic [PHI_W-1:0] phi_rom_t [ROM_DEPTH];

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;
    localparam logic [63:0] LN2_Q30 = 64'd744261118;

    // Restoring division, used only while building the gain table.
    function automatic logic [63:0] hzr_udiv(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Natural logarithm of v in 1..255, Q30.
    function automatic logic [63:0] hzr_ln_q30(input logic [63:0] v);
        int unsigned k;
        logic [63:0] mant;
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] term;
        logic [63:0] sum;
        k = 0;
        while (k < 7 && (v >> (k + 1)) != 64'd0) begin
            k++;
        end
        mant = (v << 30) >> k;
        z    = hzr_udiv((mant - Q30_ONE) << 30, mant + Q30_ONE);
        z2   = (z * z) >> 30;
        term = z;
        sum  = '0;
        for (int j = 0; j < 16; j++) begin
            sum  = sum + hzr_udiv(term, 64'(2 * j + 1));
            term = (term * z2) >> 30;
        end
        return 64'(k) * LN2_Q30 + 2 * sum;
    endfunction

    // exp(-b) for b >= 0, argument and result in Q30.
    function automatic logic [63:0] hzr_expneg_q30(input logic [63:0] b);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] term;
        logic [63:0] sum;
        n = hzr_udiv(b, LN2_Q30);
        r = b - n * LN2_Q30;
        if (n >= 64'd60) begin
            return '0;
        end
        term = Q30_ONE;
        sum  = Q30_ONE;
        for (int k = 1; k <= 20; k++) begin
            term = hzr_udiv((term * r) >> 30, 64'(k));
            sum  = sum + term;
        end
        return hzr_udiv(64'd1 << 60, sum) >> n;
    endfunction

    // Gain table phi(i) = 1 + exp(-14 * (i/255)^1.6), rounded half up.
    function automatic phi_rom_t hzr_build_phi_rom();
        phi_rom_t    rom;
        logic [63:0] ln255;
        logic [63:0] li;
        logic [63:0] a;
        logic [63:0] t;
        logic [63:0] phi;
        ln255 = hzr_ln_q30(64'd255);
        for (int i = 0; i < ROM_DEPTH; i++) begin
            if (i == 0) begin
                t = '0;
            end
            else begin
                li = hzr_ln_q30(64'(i));
                a  = (li > ln255) ? 64'd0 : ln255 - li;
                t  = hzr_expneg_q30(hzr_udiv(a * 8, 64'd5));
            end
            phi    = Q30_ONE + hzr_expneg_q30(t * 14);
            phi    = (phi + (64'd1 << (30 - PHI_FRAC_BITS - 1))) >> (30 - PHI_FRAC_BITS);
            rom[i] = phi[PHI_W-1:0];
        end
        return rom;
    endfunction

    localparam phi_rom_t PHI_ROM = hzr_build_phi_rom();

    localparam logic [PHI_W-1:0] PHI_TWO = {2'b10, {PHI_FRAC_BITS{1'b0}}};

endpackage

>>> src/hzr_in_if.sv
interface hzr_in_if
    import hzr_pkg::*;
();

    logic  valid;
    logic  ready;
    chan_t in_red;
    chan_t in_green;
    chan_t in_blue;
    logic  in_user;
    logic  in_last;

    modport source (
        output valid,
        output in_red,
        output in_green,
        output in_blue,
        output in_user,
        output in_last,
        input  ready
    );

    modport sink (
        input  valid,
        input  in_red,
        input  in_green,
        input  in_blue,
        input  in_user,
        input  in_last,
        output ready
    );

endinterface

>>> src/hzr_out_if.sv
interface hzr_out_if
    import hzr_pkg::*;
();

    logic  valid;
    logic  ready;
    chan_t out_red;
    chan_t out_green;
    chan_t out_blue;
    logic  out_user;
    logic  out_last;

    modport source (
        output valid,
        output out_red,
        output out_green,
        output out_blue,
        output out_user,
        output out_last,
        input  ready
    );

    modport sink (
        input  valid,
        input  out_red,
        input  out_green,
        input  out_blue,
        input  out_user,
        input  out_last,
        output ready
    );

endinterface

>>> src/haze_removal_pixel.sv
// Each input word passes through seven register stages, with per-stage valid bits,
// before its result word is offered; a stall at the output holds the result word.
// Throughput: one word per cycle while the output side is ready.
// A stalled stage holds its word, and empty stages upstream of it keep filling.
// Reset (rst_n, asynchronous, active low) empties the pipeline and clears both
// configuration registers to zero; the gain table is a constant and needs no fill.
`include "haze_removal_pixel_assert.svh"

module haze_removal_pixel
    import hzr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [CHAN_W-1:0]    wr_data,
    hzr_in_if.sink               pix_in,
    hzr_out_if.source            pix_out
);

    localparam int NSTG = 7;

    // Configuration registers.
    logic [CHAN_W-1:0] haze_mean_reg;
    logic [CHAN_W-1:0] haze_spread_reg;
    logic [CHAN_W-1:0] haze_mean_next;
    logic [CHAN_W-1:0] haze_spread_next;

    // Pipeline control.
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] adv;
    logic            in_acc;
    hzr_carry_t      carry_reg [NSTG];
    hzr_carry_t      carry_next;

    // Stage 1: channel minimum, haze test, floor(8 * spread / 5).
    chan_t       m_next;
    logic [10:0] thd2;
    logic [10:0] m2;
    logic [10:0] offhd2;
    logic [22:0] q_prod;
    chan_t       m_s1_reg;
    logic [8:0]  q_s1_reg;

    // Stage 2: lowered floor and luminance.
    logic [9:0]       tmsf;
    chan_t            off;
    pixel_t           adj_next;
    logic [LUM_W-1:0] lum_next;
    pixel_t           adj_s2_reg;
    logic [LUM_W-1:0] lum_reg;

    // Stage 3: table index.
    logic [27:0]          idx_prod;
    pixel_t               adj_s3_reg;
    logic [ROM_IDX_W-1:0] idx_reg;

    // Stage 4: gain lookup.
    pixel_t           adj_s4_reg;
    logic [PHI_W-1:0] phi;

    // Stage 5: channel times gain.
    logic [PROD_W-1:0] prod_r_reg;
    logic [PROD_W-1:0] prod_g_reg;
    logic [PROD_W-1:0] prod_b_reg;

    // Stage 6: times 39, divided by 8 * 2^PHI_FRAC_BITS.
    logic [X_W-1:0]   x_r;
    logic [X_W-1:0]   x_g;
    logic [X_W-1:0]   x_b;
    logic [QUO_W-1:0] quo_r_reg;
    logic [QUO_W-1:0] quo_g_reg;
    logic [QUO_W-1:0] quo_b_reg;

    // Stage 7: divided by 5, saturated, output select.
    pixel_t res_next;
    pixel_t res_reg;

    function automatic chan_t sat_div5(input logic [QUO_W-1:0] z);
        logic [QUO_W+11:0] y;
        logic [QUO_W+11-DIV5_SHIFT:0] v;
        y = (QUO_W + 12)'(z) * (QUO_W + 12)'(DIV5_RECIP);
        v = y[QUO_W+11:DIV5_SHIFT];
        return (v > (QUO_W + 12 - DIV5_SHIFT)'(255)) ? 8'hFF : v[CHAN_W-1:0];
    endfunction

    // Configuration write decode.
    always_comb
    begin
        haze_mean_next   = haze_mean_reg;
        haze_spread_next = haze_spread_reg;
        if (wr_en)
        begin
            unique case (cfg_index_t'(wr_index))
                CFG_HAZE_MEAN:   haze_mean_next   = wr_data;
                CFG_HAZE_SPREAD: haze_spread_next = wr_data;
                default:         haze_mean_next   = haze_mean_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            haze_mean_reg   <= '0;
            haze_spread_reg <= '0;
        end
        else
        begin
            haze_mean_reg   <= haze_mean_next;
            haze_spread_reg <= haze_spread_next;
        end
    end

    // A stage may load when it is empty or when its word moves on.
    always_comb
    begin
        adv[NSTG-1] = !vld_reg[NSTG-1] || pix_out.ready;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign pix_in.ready = adv[0];
    assign in_acc       = pix_in.valid && adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= pix_in.valid;
            end
            for (int i = 1; i < NSTG; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // Stage 1 arithmetic.
    always_comb
    begin
        m_next = pix_in.in_red;
        if (pix_in.in_green < m_next)
        begin
            m_next = pix_in.in_green;
        end
        if (pix_in.in_blue < m_next)
        begin
            m_next = pix_in.in_blue;
        end
        thd2   = 11'({haze_mean_reg, 1'b0}) + 11'(haze_spread_reg) * 11'(3'd5);
        m2     = 11'({m_next, 1'b0});
        offhd2 = (m2 > thd2) ? thd2 : m2;
        q_prod = 23'({haze_spread_reg, 3'b000}) * 23'(DIV5_RECIP);

        carry_next.orig.red   = pix_in.in_red;
        carry_next.orig.green = pix_in.in_green;
        carry_next.orig.blue  = pix_in.in_blue;
        carry_next.hazy       = offhd2 > 11'({haze_mean_reg, 2'b00});
        carry_next.user       = pix_in.in_user;
        carry_next.last       = pix_in.in_last;
    end

    // Side payload travels with the valid bits.
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            carry_reg[0] <= carry_next;
            m_s1_reg     <= m_next;
            q_s1_reg     <= q_prod[22:DIV5_SHIFT];
        end
        for (int i = 1; i < NSTG; i++)
        begin
            if (adv[i])
            begin
                carry_reg[i] <= carry_reg[i-1];
            end
        end
    end

    // Stage 2: floor limited by the lower threshold, then luminance.
    always_comb
    begin
        tmsf  = 10'(haze_mean_reg) + 10'(q_s1_reg);
        off   = (10'(m_s1_reg) > tmsf) ? tmsf[CHAN_W-1:0] : m_s1_reg;
        adj_next.red   = carry_reg[0].orig.red - m_s1_reg + off;
        adj_next.green = carry_reg[0].orig.green - m_s1_reg + off;
        adj_next.blue  = carry_reg[0].orig.blue - m_s1_reg + off;
        lum_next = LUM_W'(adj_next.red) * LUM_W'(LUM_WR)
                 + LUM_W'(adj_next.green) * LUM_W'(LUM_WG)
                 + LUM_W'(adj_next.blue) * LUM_W'(LUM_WB);
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            adj_s2_reg <= adj_next;
            lum_reg    <= lum_next;
        end
    end

    // Stage 3: index = floor(luminance / 100).
    assign idx_prod = 28'(lum_reg) * 28'(DIV100_RECIP);

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            adj_s3_reg <= adj_s2_reg;
            idx_reg    <= idx_prod[DIV100_SHIFT+ROM_IDX_W-1:DIV100_SHIFT];
        end
    end

    // Stage 4: gain table read.
    hzr_phi_rom u_phi_rom (
        .clk (clk),
        .en  (adv[3]),
        .idx (idx_reg),
        .phi (phi)
    );

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            adj_s4_reg <= adj_s3_reg;
        end
    end

    // Stage 5: one multiplier per channel.
    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            prod_r_reg <= PROD_W'(adj_s4_reg.red) * PROD_W'(phi);
            prod_g_reg <= PROD_W'(adj_s4_reg.green) * PROD_W'(phi);
            prod_b_reg <= PROD_W'(adj_s4_reg.blue) * PROD_W'(phi);
        end
    end

    // Stage 6: scale by 39, drop the fraction and the factor of eight.
    assign x_r = X_W'(prod_r_reg) * X_W'(6'd39);
    assign x_g = X_W'(prod_g_reg) * X_W'(6'd39);
    assign x_b = X_W'(prod_b_reg) * X_W'(6'd39);

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            quo_r_reg <= x_r[X_W-1:PHI_FRAC_BITS+3];
            quo_g_reg <= x_g[X_W-1:PHI_FRAC_BITS+3];
            quo_b_reg <= x_b[X_W-1:PHI_FRAC_BITS+3];
        end
    end

    // Stage 7: divide by five, saturate, and pass clear pixels unchanged.
    always_comb
    begin
        if (carry_reg[5].hazy)
        begin
            res_next.red   = sat_div5(quo_r_reg);
            res_next.green = sat_div5(quo_g_reg);
            res_next.blue  = sat_div5(quo_b_reg);
        end
        else
        begin
            res_next = carry_reg[5].orig;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            res_reg <= res_next;
        end
    end

    // Output word.
    assign pix_out.valid     = vld_reg[NSTG-1];
    assign pix_out.out_red   = res_reg.red;
    assign pix_out.out_green = res_reg.green;
    assign pix_out.out_blue  = res_reg.blue;
    assign pix_out.out_user  = carry_reg[NSTG-1].user;
    assign pix_out.out_last  = carry_reg[NSTG-1].last;

    // Checks on the pipeline and the gain table.
    `HZR_ASSERT_NXT(a_accept_fills, in_acc, vld_reg[0])
    `HZR_ASSERT_NXT(a_stall_keeps, vld_reg[2] && !adv[3], vld_reg[2])
    `HZR_ASSERT_IMP(a_lum_range, vld_reg[1], lum_reg <= LUM_MAX)
    `HZR_ASSERT_NXT(a_phi_dark, adv[3] && vld_reg[2] && idx_reg == '0, phi == PHI_TWO)

endmodule

>>> src/hzr_phi_rom.sv
module hzr_phi_rom
    import hzr_pkg::*;
(
    input  logic                 clk,
    input  logic                 en,
    input  logic [ROM_IDX_W-1:0] idx,
    output logic [PHI_W-1:0]     phi
);

    logic [PHI_W-1:0] phi_reg;

    // Registered lookup of the gain table; it holds while the stage stalls.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            phi_reg <= PHI_ROM[idx];
        end
    end

    assign phi = phi_reg;

endmodule

>>> tb/haze_removal_pixel_test.sv
`timescale 1ns / 1ps

module haze_removal_pixel_test
    import hzr_pkg::*;
();

    // Fraction bits of the gain used by the predictor.
    localparam int GAIN_FRAC = PHI_FRAC_BITS;
    localparam bit [63:0] ONE_Q30 = 64'd1 << 30;
    localparam bit [63:0] LN2_Q30_TB = 64'd744261118;

    // One word of the pixel stream, as sent or as received.
    typedef struct packed {
        pixel_t px;
        logic   user;
        logic   last;
    } video_word_t;

    // Holds its own copy of the registers and of the gain table, and the
    // queue of corrected pixels still to arrive.
    class haze_scoreboard;
        bit [7:0]    mean;
        bit [7:0]    spread;
        bit [31:0]   gain_table [256];
        video_word_t expected_q [$];
        int          errors;

        function new();
            bit [63:0] ln255;
            bit [63:0] li;
            bit [63:0] a;
            bit [63:0] t;
            bit [63:0] phi;
            mean   = 0;
            spread = 0;
            errors = 0;
            ln255  = ln_q30(64'd255);
            for (int i = 0; i < 256; i++)
            begin
                if (i == 0)
                begin
                    t = 0;
                end
                else
                begin
                    li = ln_q30(64'(i));
                    a  = (li > ln255) ? 64'd0 : ln255 - li;
                    t  = exp_neg_q30(a * 64'd8 / 64'd5);
                end
                phi = ONE_Q30 + exp_neg_q30(t * 64'd14);
                phi = (phi + (64'd1 << (30 - GAIN_FRAC - 1))) >> (30 - GAIN_FRAC);
                gain_table[i] = phi[31:0];
            end
        endfunction

        // Natural logarithm of v in 1..255, in Q30, by the atanh series.
        function bit [63:0] ln_q30(bit [63:0] v);
            int unsigned k;
            bit [63:0]   mant;
            bit [63:0]   z;
            bit [63:0]   z2;
            bit [63:0]   term;
            bit [63:0]   acc;
            k = 0;
            while (k < 7 && (v >> (k + 1)) != 0)
            begin
                k++;
            end
            mant = (v << 30) >> k;
            z    = ((mant - ONE_Q30) << 30) / (mant + ONE_Q30);
            z2   = (z * z) >> 30;
            term = z;
            acc  = 0;
            for (int j = 0; j < 16; j++)
            begin
                acc  = acc + term / 64'(2 * j + 1);
                term = (term * z2) >> 30;
            end
            return 64'(k) * LN2_Q30_TB + 64'd2 * acc;
        endfunction

        // exp(-b) in Q30: split off whole multiples of ln 2, Taylor series on the rest.
        function bit [63:0] exp_neg_q30(bit [63:0] b);
            bit [63:0] n;
            bit [63:0] r;
            bit [63:0] term;
            bit [63:0] acc;
            n = b / LN2_Q30_TB;
            r = b - n * LN2_Q30_TB;
            if (n >= 64'd60)
            begin
                return 64'd0;
            end
            term = ONE_Q30;
            acc  = ONE_Q30;
            for (int k = 1; k <= 20; k++)
            begin
                term = ((term * r) >> 30) / 64'(k);
                acc  = acc + term;
            end
            return ((64'd1 << 60) / acc) >> n;
        endfunction

        // Channel times gain times 0.975, saturated at full scale.
        function chan_t scale_channel(int unsigned c, bit [31:0] phi);
            bit [63:0] v;
            v = 64'(c) * 64'(phi) * 64'd39 / (64'd40 << GAIN_FRAC);
            return (v > 64'd255) ? chan_t'(255) : chan_t'(v);
        endfunction

        // Corrected pixel for one input word under the current registers.
        function video_word_t correct_pixel(video_word_t w);
            video_word_t res;
            int unsigned r;
            int unsigned g;
            int unsigned b;
            int unsigned m;
            int unsigned thd2;
            int unsigned offhd2;
            int unsigned tmsf10;
            int unsigned base;
            int unsigned idx;
            r = w.px.red;
            g = w.px.green;
            b = w.px.blue;
            m = r;
            if (g < m)
                m = g;
            if (b < m)
                m = b;
            thd2   = 2 * mean + 5 * spread;
            offhd2 = (2 * m > thd2) ? thd2 : 2 * m;
            res    = w;
            if (offhd2 > 4 * mean)
            begin
                // Hazy: lower the channel floor, then boost by the luminance gain.
                tmsf10 = 10 * mean + 16 * spread;
                base   = (10 * m > tmsf10) ? tmsf10 / 10 : m;
                r      = r - m + base;
                g      = g - m + base;
                b      = b - m + base;
                idx    = (27 * r + 67 * g + 6 * b) / 100;
                if (idx > 255)
                    idx = 255;
                res.px.red   = scale_channel(r, gain_table[idx]);
                res.px.green = scale_channel(g, gain_table[idx]);
                res.px.blue  = scale_channel(b, gain_table[idx]);
            end
            return res;
        endfunction

        function void note_input(video_word_t w);
            expected_q.push_back(correct_pixel(w));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string msg);
            if (errors < 40)
                $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        // Compares a received word field by field with the oldest expectation.
        task check_result(video_word_t got);
            video_word_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected word %h", got));
                return;
            end
            want = expected_q.pop_front();
            if (got.px.red !== want.px.red)
                report($sformatf("red %0d, expected %0d", got.px.red, want.px.red));
            if (got.px.green !== want.px.green)
                report($sformatf("green %0d, expected %0d", got.px.green, want.px.green));
            if (got.px.blue !== want.px.blue)
                report($sformatf("blue %0d, expected %0d", got.px.blue, want.px.blue));
            if (got.user !== want.user)
                report($sformatf("user %b, expected %b", got.user, want.user));
            if (got.last !== want.last)
                report($sformatf("last %b, expected %b", got.last, want.last));
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [CHAN_W-1:0]    wr_data;
    int                   idle_pct;
    haze_scoreboard       book;

    hzr_in_if  pix_in ();
    hzr_out_if pix_out ();

    haze_removal_pixel uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .pix_in   (pix_in),
        .pix_out  (pix_out)
    );

    // Clock.
    always #5 clk = ~clk;

    // Receiving side: check each accepted word and stall at random.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && pix_out.valid === 1'b1 && pix_out.ready === 1'b1)
        begin
            book.check_result({pix_out.out_red, pix_out.out_green, pix_out.out_blue,
                               pix_out.out_user, pix_out.out_last});
        end
        pix_out.ready <= ($urandom_range(0, 99) >= idle_pct);
    end

    // Offers one word after a random gap and waits for it to be taken.
    task send_word(video_word_t w);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            pix_in.valid <= 1'b0;
            @(posedge clk);
        end
        pix_in.valid    <= 1'b1;
        pix_in.in_red   <= w.px.red;
        pix_in.in_green <= w.px.green;
        pix_in.in_blue  <= w.px.blue;
        pix_in.in_user  <= w.user;
        pix_in.in_last  <= w.last;
        @(posedge clk);
        while (pix_in.ready !== 1'b1)
            @(posedge clk);
        book.note_input(w);
    endtask

    task send_rgb(int r, int g, int b, bit user, bit last);
        send_word({chan_t'(r), chan_t'(g), chan_t'(b), user, last});
    endtask

    // Lets the pipeline drain, then writes both statistics registers.
    task load_config(int mean, int spread);
        pix_in.valid <= 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= CFG_HAZE_MEAN;
        wr_data  <= CHAN_W'(mean);
        @(posedge clk);
        book.mean = 8'(mean);
        wr_index  <= CFG_HAZE_SPREAD;
        wr_data   <= CHAN_W'(spread);
        @(posedge clk);
        book.spread = 8'(spread);
        wr_en       <= 1'b0;
    endtask

    // Random pixel; most have every channel above the haze test, so that the
    // correction path is taken often.
    function automatic video_word_t make_word();
        video_word_t w;
        int unsigned lo;
        int unsigned base;
        int unsigned pick;
        w.px.red   = chan_t'($urandom);
        w.px.green = chan_t'($urandom);
        w.px.blue  = chan_t'($urandom);
        w.user     = ($urandom_range(0, 9) == 0);
        w.last     = ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 9) < 6)
        begin
            lo = 2 * book.mean + 1;
            if (lo > 255)
                lo = 255;
            base       = $urandom_range(255, lo);
            w.px.red   = chan_t'($urandom_range(255, base));
            w.px.green = chan_t'($urandom_range(255, base));
            w.px.blue  = chan_t'($urandom_range(255, base));
            pick       = $urandom_range(0, 2);
            if (pick == 0)
                w.px.red = chan_t'(base);
            else if (pick == 1)
                w.px.green = chan_t'(base);
            else
                w.px.blue = chan_t'(base);
        end
        return w;
    endfunction

    task run_random(int count);
        for (int i = 0; i < count; i++)
            send_word(make_word());
    endtask

    // Main sequence.
    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        wr_en           = 1'b0;
        wr_index        = CFG_HAZE_MEAN;
        wr_data         = '0;
        pix_in.valid    = 1'b0;
        pix_in.in_red   = '0;
        pix_in.in_green = '0;
        pix_in.in_blue  = '0;
        pix_in.in_user  = 1'b0;
        pix_in.in_last  = 1'b0;
        pix_out.ready   = 1'b0;
        idle_pct        = 24;
        book            = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero statistics: both thresholds are zero, so every pixel passes unchanged.
        load_config(0, 0);
        send_rgb(0, 0, 0, 1'b1, 1'b0);
        send_rgb(255, 255, 255, 1'b0, 1'b1);
        send_rgb(255, 1, 1, 1'b0, 0);
        send_rgb(1, 1, 1, 1'b1, 1'b1);
        send_rgb(255, 0, 128, 1'b0, 1'b0);
        send_rgb(128, 64, 255, 1'b0, 1'b1);
        send_rgb(0, 255, 255, 1'b1, 1'b0);
        send_rgb(200, 200, 1, 1'b0, 1'b0);
        run_random(40);

        // Floor kept at the minimum, floor cut to the lower threshold, and the
        // boundaries of the haze test.
        load_config(10, 50);
        send_rgb(60, 80, 100, 1'b1, 1'b0);
        send_rgb(200, 210, 220, 1'b0, 1'b1);
        send_rgb(20, 100, 100, 1'b0, 1'b0);
        send_rgb(21, 30, 40, 1'b0, 1'b0);
        send_rgb(255, 255, 254, 1'b1, 1'b1);
        send_rgb(90, 90, 90, 1'b0, 1'b0);
        send_rgb(91, 200, 100, 1'b0, 1'b1);
        run_random(40);

        // Upper threshold below twice the mean: nothing is hazy.
        load_config(100, 0);
        send_rgb(255, 255, 255, 1'b0, 1'b0);
        send_rgb(150, 160, 170, 1'b1, 1'b1);
        run_random(30);

        load_config(255, 255);
        run_random(40);
        load_config(0, 255);
        run_random(50);
        load_config(255, 0);
        run_random(30);

        // A long stretch with neither side idling.
        idle_pct = 0;
        load_config(30, 10);
        run_random(120);
        idle_pct = 24;

        for (int p = 0; p < 3; p++)
        begin
            load_config($urandom_range(0, 120), $urandom_range(0, 255));
            run_random(50);
        end

        // Let the last words drain, then give the verdict.
        pix_in.valid <= 1'b0;
        for (int i = 0; i < 2000 && book.pending() != 0; i++)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (book.pending() != 0)
            book.report($sformatf("%0d words never arrived", book.pending()));
        if (book.errors == 0)
        begin
            $display("[haze_removal_pixel] OK");
        end
        else
        begin
            $display("[haze_removal_pixel] ERROR");
        end
        $finish;
    end

    // Watchdog.
    initial
    begin
        #5000000;
        $display("[haze_removal_pixel] ERROR");
        $finish;
    end

endmodule
